// File: src/xyp_pkg.sv
// Shared types, constants and arithmetic helpers of the XY persistence accumulator.
package xyp_pkg;

	// Default store geometry.
	localparam int DEF_MAX_WIDTH  = 320;
	localparam int DEF_MAX_HEIGHT = 240;

	// Field and register widths.
	localparam int FW_W    = 9;
	localparam int FH_W    = 8;
	localparam int SAMP_W  = 16;
	localparam int INT_W   = 8;
	localparam int COLOR_W = 11;

	// A linear index y * width + x with a 9-bit width and 8-bit row always fits here.
	localparam int IDX_W = 17;

	// Depth of the command queue between the front and the back end.
	localparam int QUEUE_DEPTH = 4;

	// Register reset values.
	localparam logic [FW_W-1:0] FW_RESET = 9'd320;
	localparam logic [FH_W-1:0] FH_RESET = 8'd240;

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_DECAY  = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	typedef enum logic [1:0] {
		OP_DECAY,
		OP_SAMPLE,
		OP_READ
	} op_t;

	// Effective plot geometry, already saturated.
	typedef struct packed {
		logic [FW_W-1:0] wd;
		logic [FH_W-1:0] ht;
	} geom_t;

	// One command word in the queue.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             in_region;
	} cmd_t;

	// Status reported by the back end.
	typedef struct packed {
		logic clearing;
	} back_status_t;

	// Truncating division of a product below 65535 * 511 by 65535.
	// Splitting at bit 16 leaves a remainder below twice the divisor, so one
	// compare corrects the quotient.
	function automatic logic [8:0] div65535(input logic [24:0] p);
		logic [8:0]  q0;
		logic [16:0] r;
		q0 = p[24:16];
		r  = {1'b0, p[15:0]} + {8'b0, q0};
		return q0 + {8'b0, (r >= 17'd65535)};
	endfunction

	// Green-only RGB565 colour of an intensity: (v * 63 / 255) << 5.
	function automatic logic [COLOR_W-1:0] green565(input logic [INT_W-1:0] v);
		logic [13:0] t;
		logic [14:0] s;
		t = {6'b0, v} * 14'd63;
		s = {1'b0, t} + {9'b0, t[13:8]} + 15'd1;
		return {s[13:8], 5'b0};
	endfunction

endpackage

// File: src/xyp_front.sv
// Front end: accepts input words, maps samples to store indexes and queues commands.
module xyp_front import xyp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic signed [SAMP_W-1:0] ch1_sample,
	input  logic signed [SAMP_W-1:0] ch2_sample,
	input  logic [FW_W-1:0]          pixel_x,
	input  logic [FH_W-1:0]          pixel_y,
	input  geom_t                    geom,
	output logic                     push,
	output cmd_t                     cmd,
	input  logic                     full
);

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [1:0]        kind_s1;
	logic [SAMP_W-1:0] sx_s1, sy_s1;
	logic [FW_W-1:0]   x_s1;
	logic [FH_W-1:0]   y_s1;

	op_t               op_s2;
	logic [24:0]       prodx_s2;
	logic [23:0]       prody_s2;
	logic [IDX_W-1:0]  rowp_s2;
	logic [FW_W-1:0]   x_s2;
	logic              inreg_s2;

	op_t               op_s3;
	logic [FW_W-1:0]   px_s3;
	logic [FH_W-1:0]   py_s3;
	logic [IDX_W-1:0]  rowp_s3;
	logic [FW_W-1:0]   x_s3;
	logic              inreg_s3;

	op_t               op_s4;
	logic [IDX_W-1:0]  base_s4;
	logic [FW_W-1:0]   off_s4;
	logic              inreg_s4;

	logic [FW_W-1:0]   w_c;
	logic [FH_W-1:0]   h_c;
	logic              kind_ok_c;
	op_t               op_c;
	logic [8:0]        qy_c;

	assign w_c = geom.wd - 9'd1;
	assign h_c = geom.ht - 8'd1;

	// Stall chain: a stage loads when it is empty or its word moves on.
	assign push     = v_s4 && !full;
	assign en4      = !v_s4 || !full;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// Classify the kind; unused kinds are dropped here.
	always_comb begin
		kind_ok_c = 1'b1;
		unique case (kind_s1)
			KIND_DECAY:  op_c = OP_DECAY;
			KIND_SAMPLE: op_c = OP_SAMPLE;
			KIND_READ:   op_c = OP_READ;
			default: begin
				op_c      = OP_DECAY;
				kind_ok_c = 1'b0;
			end
		endcase
	end

	assign qy_c = div65535({1'b0, prody_s2});

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1 && kind_ok_c;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage one captures the word; flipping bit 15 offsets the samples by 32768.
	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= kind;
			sx_s1   <= ch1_sample ^ 16'h8000;
			sy_s1   <= ch2_sample ^ 16'h8000;
			x_s1    <= pixel_x;
			y_s1    <= pixel_y;
		end
	end

	// Stage two forms the scaling products and the read row offset.
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2    <= op_c;
			prodx_s2 <= {9'b0, sx_s1} * {16'b0, w_c};
			prody_s2 <= {8'b0, sy_s1} * {16'b0, h_c};
			rowp_s2  <= {9'b0, y_s1} * {8'b0, geom.wd};
			x_s2     <= x_s1;
			inreg_s2 <= (x_s1 < geom.wd) && (y_s1 < geom.ht);
		end
	end

	// Stage three divides by 65535 and inverts the vertical axis.
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3    <= op_s2;
			px_s3    <= div65535(prodx_s2);
			py_s3    <= h_c - qy_c[7:0];
			rowp_s3  <= rowp_s2;
			x_s3     <= x_s2;
			inreg_s3 <= inreg_s2;
		end
	end

	// Stage four forms the sample row offset.
	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4 <= op_s3;
			if (op_s3 == OP_SAMPLE) begin
				base_s4  <= {9'b0, py_s3} * {8'b0, geom.wd};
				off_s4   <= px_s3;
				inreg_s4 <= 1'b1;
			end else begin
				base_s4  <= rowp_s3;
				off_s4   <= x_s3;
				inreg_s4 <= inreg_s3;
			end
		end
	end

	// Command word into the queue.
	assign cmd.op        = op_s4;
	assign cmd.idx       = base_s4 + {8'b0, off_s4};
	assign cmd.in_region = inreg_s4;

endmodule

// File: src/xyp_fifo.sv
// Short command queue between the front and the back end.
module xyp_fifo import xyp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = slot_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(QUEUE_DEPTH)))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("command queue read while empty");

endmodule

// File: src/xyp_back.sv
// Back end: intensity store with clearing pass, decay sweep, sample update and pixel read.
module xyp_back import xyp_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  geom_t               geom,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COLOR_W-1:0]  pixel_color,
	output logic                pixel_lit,
	output back_status_t        status
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_DECAY,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	cmd_t               cur_q;
	logic [AW-1:0]      sweep_q;
	logic [FW_W-1:0]    col_q;
	logic [FH_W-1:0]    row_q;
	logic               wv_q;
	logic [AW-1:0]      wa_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               pixel_lit_q;

	logic [INT_W-1:0]   mem [DEPTH];
	logic [INT_W-1:0]   rd_q;

	logic               mem_re, mem_we;
	logic [AW-1:0]      mem_ra, mem_wa;
	logic [INT_W-1:0]   mem_wd;

	// A read needs the result register free by the time its data arrives.
	assign pop = (state_q == ST_IDLE) && cmd_valid &&
		((cmd.op != OP_READ) || !out_valid_q || out_ready);

	assign out_valid       = out_valid_q;
	assign pixel_color     = pixel_color_q;
	assign pixel_lit       = pixel_lit_q;
	assign status.clearing = (state_q == ST_CLEAR);

	// Store port control.
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
			end
			ST_IDLE: begin
				if (pop && (cmd.op != OP_DECAY) && cmd.in_region) begin
					mem_re = 1'b1;
					mem_ra = AW'(cmd.idx);
				end
			end
			ST_ACCESS: begin
				if (cur_q.op == OP_SAMPLE) begin
					mem_we = 1'b1;
					mem_wa = AW'(cur_q.idx);
					mem_wd = (rd_q == 8'hFF) ? rd_q : rd_q + 8'd1;
				end
			end
			ST_DECAY: begin
				mem_re = 1'b1;
				mem_ra = sweep_q;
			end
			ST_DRAIN: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
		// Decay write-back comes in the cycle after its read.
		if (wv_q) begin
			mem_we = 1'b1;
			mem_wa = wa_q;
			mem_wd = rd_q - {7'b0, (rd_q != '0)};
		end
	end

	// Intensity store.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cur_q         <= '0;
			sweep_q       <= '0;
			col_q         <= '0;
			row_q         <= '0;
			wv_q          <= 1'b0;
			wa_q          <= '0;
			out_valid_q   <= 1'b0;
			pixel_color_q <= '0;
			pixel_lit_q   <= 1'b0;
		end else begin
			wv_q <= (state_q == ST_DECAY);
			wa_q <= sweep_q;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(DEPTH - 1)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cur_q <= cmd;
						if (cmd.op == OP_DECAY) begin
							sweep_q <= '0;
							col_q   <= '0;
							row_q   <= '0;
							state_q <= ST_DECAY;
						end else begin
							state_q <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					if (cur_q.op == OP_READ) begin
						out_valid_q   <= 1'b1;
						pixel_lit_q   <= cur_q.in_region && (rd_q != '0);
						pixel_color_q <= cur_q.in_region ? green565(rd_q) : '0;
					end
					state_q <= ST_IDLE;
				end
				ST_DECAY: begin
					sweep_q <= sweep_q + 1'b1;
					if (col_q == geom.wd - 9'd1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
						if (row_q == geom.ht - 8'd1) state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCESS && cur_q.op == OP_READ) |-> !out_valid_q)
		else $error("read result would overwrite a waiting word");

	a_decay_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		wv_q |-> (state_q == ST_DECAY || state_q == ST_DRAIN))
		else $error("decay write-back outside the decay sweep");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_CLEAR) |-> ($past(sweep_q) == AW'(DEPTH - 1)))
		else $error("clearing pass left before the last entry");

endmodule

// File: src/xy_persistence_accumulator.sv
// Top level of the XY persistence accumulator: configuration registers and block wiring.
//
//  Channel   Handshake              Carries
//  -------   ---------------------  -----------------------------------------------
//  in        in_valid / in_ready    kind, ch1_sample, ch2_sample, pixel_x, pixel_y
//  out       out_valid / out_ready  pixel_color, pixel_lit (read words only)
//  cfg       cfg_we                 cfg_index, cfg_data (frame_width, frame_height)
//
// Samples and reads first read the store, then write it back or register the result.
// The front end is pipelined. A decay word sweeps all width * height entries, reading
// one entry while writing back another. After reset a clearing pass over all
// MAX_WIDTH * MAX_HEIGHT entries (76800 by default) zeroes the store; in_ready stays
// low throughout it. A stalled output holds back a read word at the queue head and
// the words behind it; input is taken until the front stages and the queue fill.
module xy_persistence_accumulator import xyp_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic signed [SAMP_W-1:0] ch1_sample,
	input  logic signed [SAMP_W-1:0] ch2_sample,
	input  logic [FW_W-1:0]          pixel_x,
	input  logic [FH_W-1:0]          pixel_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COLOR_W-1:0]       pixel_color,
	output logic                     pixel_lit,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [FW_W-1:0]          cfg_data
);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	geom_t           geom;
	back_status_t    status;
	logic            front_ready;
	logic            push, full, pop, not_empty;
	cmd_t            push_cmd, pop_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// Saturate the geometry to the range the store supports.
	always_comb begin
		if (frame_width_q < 9'd2)
			geom.wd = 9'd2;
		else if ({23'b0, frame_width_q} > MAX_WIDTH)
			geom.wd = FW_W'(MAX_WIDTH);
		else
			geom.wd = frame_width_q;
		if (frame_height_q < 8'd2)
			geom.ht = 8'd2;
		else if ({24'b0, frame_height_q} > MAX_HEIGHT)
			geom.ht = FH_W'(MAX_HEIGHT);
		else
			geom.ht = frame_height_q;
	end

	// No words are taken during the clearing pass.
	assign in_ready = front_ready && !status.clearing;

	xyp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid && !status.clearing),
		.in_ready   (front_ready),
		.kind       (kind),
		.ch1_sample (ch1_sample),
		.ch2_sample (ch2_sample),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.geom       (geom),
		.push       (push),
		.cmd        (push_cmd),
		.full       (full)
	);

	xyp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	xyp_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.cmd_valid   (not_empty),
		.cmd         (pop_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color),
		.pixel_lit   (pixel_lit),
		.status      (status)
	);

endmodule
